/* rtl/wavhc_pkg.sv */
// ----------------------------------------------------------------------------
// wavhc_pkg
// Shared types, codes and tag tables of the RIFF/WAVE header checker.
// ----------------------------------------------------------------------------
package wavhc_pkg;

	typedef enum logic [3:0] {
		VERDICT_OK        = 4'd0,
		VERDICT_RIFF      = 4'd1,
		VERDICT_WAVE      = 4'd2,
		VERDICT_FMT       = 4'd3,
		VERDICT_CHANS     = 4'd4,
		VERDICT_RATE      = 4'd5,
		VERDICT_BITS      = 4'd6,
		VERDICT_DATA      = 4'd7,
		VERDICT_LENGTH    = 4'd8,
		VERDICT_BAD_CHANS = 4'd9,
		VERDICT_BAD_BITS  = 4'd10
	} verdict_t;

	typedef enum logic [2:0] {
		REG_EXP_CHANNELS = 3'd0,
		REG_EXP_RATE     = 3'd1,
		REG_EXP_BITS     = 3'd2,
		REG_MIN_FRAMES   = 3'd3,
		REG_MAX_FRAMES   = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		TAG_RIFF = 2'd0,
		TAG_WAVE = 2'd1,
		TAG_FMT  = 2'd2,
		TAG_DATA = 2'd3
	} tag_sel_t;

	localparam int unsigned REG_INDEX_W = 3;
	localparam logic [15:0] FMT_SIZE_EXT = 16'd18;
	localparam logic [15:0] BITS_16      = 16'd16;
	localparam logic [15:0] BITS_8       = 16'd8;
	localparam logic [15:0] CHANS_MONO   = 16'd1;
	localparam logic [15:0] CHANS_STEREO = 16'd2;

	typedef struct packed {
		logic [15:0]        exp_channels;
		logic [31:0]        exp_rate;
		logic [15:0]        exp_bits;
		logic signed [31:0] min_frames;
		logic signed [31:0] max_frames;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		verdict_t           verdict;
		logic signed [31:0] frames;
	} result_t;

	function automatic logic [7:0] tag_char(tag_sel_t sel, logic [1:0] idx);
		logic [31:0] word;
		case (sel)
			TAG_RIFF: word = {8'h52, 8'h49, 8'h46, 8'h46};
			TAG_WAVE: word = {8'h57, 8'h41, 8'h56, 8'h45};
			TAG_FMT:  word = {8'h66, 8'h6D, 8'h74, 8'h20};
			TAG_DATA: word = {8'h64, 8'h61, 8'h74, 8'h61};
			default:  word = '0;
		endcase
		case (idx)
			2'd0:    return word[31:24];
			2'd1:    return word[23:16];
			2'd2:    return word[15:8];
			default: return word[7:0];
		endcase
	endfunction

endpackage

/* rtl/wavhc_cfg.sv */
// ----------------------------------------------------------------------------
// wavhc_cfg
// Configuration registers, written one at a time by index.
// ----------------------------------------------------------------------------
module wavhc_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [wavhc_pkg::REG_INDEX_W-1:0]     wr_index,
	input  logic [31:0]                           wr_data,
	output wavhc_pkg::cfg_t                       cfg
);

	wavhc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exp_channels <= 16'd1;
			cfg_q.exp_rate     <= 32'd44100;
			cfg_q.exp_bits     <= 16'd16;
			cfg_q.min_frames   <= 32'sd0;
			cfg_q.max_frames   <= 32'sh7FFF_FFFF;
		end else if (wr_en) begin
			case (wavhc_pkg::reg_index_t'(wr_index))
				wavhc_pkg::REG_EXP_CHANNELS: cfg_q.exp_channels <= wr_data[15:0];
				wavhc_pkg::REG_EXP_RATE:     cfg_q.exp_rate     <= wr_data;
				wavhc_pkg::REG_EXP_BITS:     cfg_q.exp_bits     <= wr_data[15:0];
				wavhc_pkg::REG_MIN_FRAMES:   cfg_q.min_frames   <= $signed(wr_data);
				wavhc_pkg::REG_MAX_FRAMES:   cfg_q.max_frames   <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/wavhc_parser.sv */
// ----------------------------------------------------------------------------
// wavhc_parser
// Byte-serial header parse: tag matching, field assembly and the verdict.
// ----------------------------------------------------------------------------
module wavhc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        file_byte,
	input  logic              start_of_file,
	input  wavhc_pkg::cfg_t   cfg,
	output wavhc_pkg::result_t res
);

	logic [5:0]  pos_q;
	logic [31:0] shift_q;
	logic [31:0] fmt_size_q;
	logic [15:0] chans_q;
	logic [15:0] bits_q;
	logic        given_q;

	logic        active;
	logic [5:0]  pos;
	logic [31:0] new_shift;
	logic [5:0]  base;
	logic [5:0]  rel;
	logic [31:0] frames;
	logic        ld_fmt;
	logic        ld_chans;
	logic        ld_bits;
	wavhc_pkg::result_t r;

	assign active    = start_of_file || !given_q;
	assign pos       = start_of_file ? 6'd0 : pos_q;
	assign new_shift = {file_byte, (start_of_file ? 24'd0 : shift_q[31:8])};
	assign base      = (fmt_size_q == {16'd0, wavhc_pkg::FMT_SIZE_EXT}) ? 6'd38 : 6'd36;
	assign rel       = pos - base;

	always_comb begin
		r        = '0;
		r.verdict = wavhc_pkg::VERDICT_OK;
		frames   = new_shift;
		ld_fmt   = 1'b0;
		ld_chans = 1'b0;
		ld_bits  = 1'b0;
		if (pos inside {[6'd0:6'd3]}) begin
			if (file_byte != wavhc_pkg::tag_char(wavhc_pkg::TAG_RIFF, pos[1:0])) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_RIFF;
			end
		end else if (pos inside {[6'd8:6'd11]}) begin
			if (file_byte != wavhc_pkg::tag_char(wavhc_pkg::TAG_WAVE, pos[1:0])) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_WAVE;
			end
		end else if (pos inside {[6'd12:6'd15]}) begin
			if (file_byte != wavhc_pkg::tag_char(wavhc_pkg::TAG_FMT, pos[1:0])) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_FMT;
			end
		end else if (pos == 6'd19) begin
			ld_fmt = 1'b1;
		end else if (pos == 6'd23) begin
			ld_chans = 1'b1;
			if (new_shift[31:16] != cfg.exp_channels) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_CHANS;
			end
		end else if (pos == 6'd27) begin
			if (new_shift != cfg.exp_rate) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_RATE;
			end
		end else if (pos == 6'd35) begin
			ld_bits = 1'b1;
			if (new_shift[31:16] != cfg.exp_bits) begin
				r.valid   = 1'b1;
				r.verdict = wavhc_pkg::VERDICT_BITS;
			end
		end else if (pos >= base) begin
			if (rel < 6'd4) begin
				if (file_byte != wavhc_pkg::tag_char(wavhc_pkg::TAG_DATA, rel[1:0])) begin
					r.valid   = 1'b1;
					r.verdict = wavhc_pkg::VERDICT_DATA;
				end
			end else if (rel >= 6'd7) begin
				r.valid = 1'b1;
				if (bits_q == wavhc_pkg::BITS_16 || bits_q == wavhc_pkg::BITS_8) begin
					if (chans_q == wavhc_pkg::CHANS_MONO) begin
						frames = (bits_q == wavhc_pkg::BITS_16) ? (new_shift >> 1) : new_shift;
					end else if (chans_q == wavhc_pkg::CHANS_STEREO) begin
						frames = (bits_q == wavhc_pkg::BITS_16) ? (new_shift >> 2)
							: (new_shift >> 1);
					end else begin
						r.verdict = wavhc_pkg::VERDICT_BAD_CHANS;
					end
					if (r.verdict == wavhc_pkg::VERDICT_OK) begin
						r.frames = $signed(frames);
						if ($signed(frames) < cfg.min_frames
							|| $signed(frames) > cfg.max_frames) begin
							r.verdict = wavhc_pkg::VERDICT_LENGTH;
						end
					end
				end else begin
					r.verdict = wavhc_pkg::VERDICT_BAD_BITS;
				end
			end
		end
		r.valid = r.valid && take && active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			shift_q    <= '0;
			fmt_size_q <= '0;
			chans_q    <= '0;
			bits_q     <= '0;
			given_q    <= 1'b1;
		end else if (take && active) begin
			shift_q <= new_shift;
			given_q <= r.valid;
			pos_q   <= r.valid ? pos : pos + 6'd1;
			if (ld_fmt) begin
				fmt_size_q <= new_shift;
			end
			if (ld_chans) begin
				chans_q <= new_shift[31:16];
			end
			if (ld_bits) begin
				bits_q <= new_shift[31:16];
			end
		end
	end

	assign res = r;

`ifndef NO_ASSERTIONS
	// A verdict always closes the file until the next start marker.
	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		r.valid |=> given_q)
		else $error("parser did not go idle after a verdict");

	// The header never runs past the last data size byte.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 6'd45)
		else $error("byte position beyond header end");

	// Without a start marker an idle parser keeps its place.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		given_q && !(take && start_of_file) |=> given_q && $stable(pos_q))
		else $error("idle parser changed state");
`endif

endmodule

/* rtl/wavhc_out_buf.sv */
// ----------------------------------------------------------------------------
// wavhc_out_buf
// Output register with a skid stage so that input transfers continue while
// a verdict waits to be taken.
// ----------------------------------------------------------------------------
module wavhc_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  wavhc_pkg::result_t push,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_ready,
	output wavhc_pkg::verdict_t out_verdict,
	output logic signed [31:0] out_frames
);

	logic               out_valid_q;
	logic               skid_valid_q;
	wavhc_pkg::verdict_t out_verdict_q;
	logic signed [31:0] out_frames_q;
	wavhc_pkg::verdict_t skid_verdict_q;
	logic signed [31:0] skid_frames_q;
	logic               drain;

	assign drain    = !out_valid_q || out_ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || push.valid;
			skid_valid_q <= skid_valid_q && push.valid;
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_verdict_q <= skid_verdict_q;
				out_frames_q  <= skid_frames_q;
				skid_verdict_q <= push.verdict;
				skid_frames_q  <= push.frames;
			end else begin
				out_verdict_q <= push.verdict;
				out_frames_q  <= push.frames;
			end
		end else if (push.valid) begin
			skid_verdict_q <= push.verdict;
			skid_frames_q  <= push.frames;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = out_verdict_q;
	assign out_frames  = out_frames_q;

`ifndef NO_ASSERTIONS
	// The skid stage only fills behind a held output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full with empty output register");

	// No push arrives while the skid stage is occupied.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push.valid)
		else $error("verdict pushed into a full buffer");

	// A verdict pushed into an empty buffer shows next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !out_valid_q |=> out_valid_q)
		else $error("pushed verdict did not reach the output");
`endif

endmodule

/* rtl/wav_header_checker.sv */
// A verdict is formed combinationally from the byte that decides it and registered in the output buffer.
// Throughput: one file byte per cycle while in_ready is high; the parse state updates in a single pass.
// The two-entry output buffer stalls input only when two verdicts are waiting.
// Reset: configuration returns to its defaults and the parser is idle until a start marker.
// ----------------------------------------------------------------------------
// wav_header_checker
// Byte-serial RIFF/WAVE header checker with a configurable format check and
// a frame count range check, giving one verdict per file.
// ----------------------------------------------------------------------------
module wav_header_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            file_byte,
	input  logic                                  start_of_file,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [3:0]                            verdict,
	output logic signed [31:0]                    frame_count,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wavhc_pkg::REG_INDEX_W-1:0]     cfg_index,
	input  logic [31:0]                           cfg_data
);

	wavhc_pkg::cfg_t     cfg;
	wavhc_pkg::result_t  res;
	wavhc_pkg::verdict_t out_verdict;
	logic                can_push;
	logic                take;

	assign cfg_ready = 1'b1;
	assign in_ready  = can_push;
	assign take      = in_valid && in_ready;

	wavhc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wavhc_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.file_byte     (file_byte),
		.start_of_file (start_of_file),
		.cfg           (cfg),
		.res           (res)
	);

	wavhc_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (res),
		.can_push    (can_push),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_verdict (out_verdict),
		.out_frames  (frame_count)
	);

	assign verdict = out_verdict;

endmodule
